[src/dbc_pkg.sv]
// ----------------------------------------------------------------------------
// dbc_pkg
// shared constants, types and the quarter-wave-free sine table for the
// demodulating bin correlator
// ----------------------------------------------------------------------------
package dbc_pkg;

  // block dimensions
  localparam int NUM_BINS    = 8;
  localparam int MAX_SAMPLES = 8192;
  localparam int SINE_DEPTH  = 1024;
  localparam int PHASE_BITS  = 24;

  localparam int SINE_ABITS  = $clog2(SINE_DEPTH);
  localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int QUARTER_IDX = SINE_DEPTH / 4;

  // field widths
  localparam int SAMPLE_W    = 12;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int BIN_IDX_W   = 3;
  localparam int SINE_W      = 16;
  localparam int MIX_W       = SAMPLE_W + 1 + SINE_W;   // sample times carrier
  localparam int M_W         = MIX_W - 15;              // mixed value after >>> 15
  localparam int CPROD_W     = M_W + SINE_W;            // mixed value times bin sine
  localparam int SUM_W       = 41;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SPACING    = 2'd2;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] CARRIER_STEP_RST   = 24'd5592405;
  localparam logic [CFG_DATA_W-1:0] FIRST_BIN_STEP_RST = 24'd2237;
  localparam logic [CFG_DATA_W-1:0] BIN_SPACING_RST    = 24'd2237;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic [PHASE_BITS-1:0]   phase_t;
  typedef logic [SINE_ABITS-1:0]   sine_idx_t;
  typedef logic signed [SINE_W-1:0] sine_t;
  typedef sine_t sine_tab_t [SINE_DEPTH];

  // mixed sample travelling along the cell row
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic signed [M_W-1:0] m;
  } tok_t;

  // finished bin result held in a cell
  typedef struct packed {
    logic                    full;
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
  } res_t;

  // pi and half pi in Q30
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned PI_HALF_Q30 = PI_Q30 / 2;

  // floor quotient by shift and subtract, only used while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // one table entry: taylor series on the angle folded into [-pi/2, pi/2]
  function automatic sine_t sine_entry(int unsigned k);
    longint          x;
    longint          acc;
    longint          pi_s;
    longint          pi_h;
    longint unsigned a;
    longint unsigned t;
    longint unsigned v;
    bit              neg;
    pi_s = longint'(PI_Q30);
    pi_h = longint'(PI_HALF_Q30);
    x    = longint'((64'd2 * PI_Q30 * longint'(k)) >> SINE_ABITS);
    if (x > pi_s) x = x - 2 * pi_s;
    if (x > pi_h) x = pi_s - x;
    if (x < -pi_h) x = -pi_s - x;
    neg = (x < 0);
    a   = longint'(neg ? -x : x);
    t   = a;
    acc = longint'(a);
    for (int n = 1; n <= 12; n++) begin
      t = (t * a) >> 30;
      t = (t * a) >> 30;
      t = udiv(t, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return neg ? -sine_t'(v[SINE_W-1:0]) : sine_t'(v[SINE_W-1:0]);
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

  // table address of the sine at a phase
  function automatic sine_idx_t sine_idx(phase_t p);
    return p[PHASE_BITS-1 -: SINE_ABITS];
  endfunction

  // cosine is the sine a quarter turn on
  function automatic sine_idx_t cos_idx(phase_t p);
    return sine_idx(p) + SINE_ABITS'(QUARTER_IDX);
  endfunction

endpackage

[src/dbc_front.sv]
// ----------------------------------------------------------------------------
// dbc_front
// carrier oscillator and mixer: turns each accepted sample into a mixed value
// ----------------------------------------------------------------------------
module dbc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [11:0]      sample,
  input  logic             last_sample,
  input  dbc_pkg::phase_t  carrier_step,
  output dbc_pkg::tok_t    tok_out
);
  import dbc_pkg::*;

  phase_t                    carrier_phase_r;
  logic                      s0_valid_r;
  logic                      s0_last_r;
  logic [SAMPLE_W-1:0]       s0_sample_r;
  sine_t                     car_cos_r;
  logic                      s1_valid_r;
  logic                      s1_last_r;
  logic signed [MIX_W-1:0]   mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_phase_r <= '0;
      s0_valid_r      <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      s0_valid_r <= accept;
      s1_valid_r <= s0_valid_r;
      if (accept) begin
        carrier_phase_r <= last_sample ? '0 : carrier_phase_r + carrier_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_sample_r <= sample;
      s0_last_r   <= last_sample;
      car_cos_r   <= SINE_TABLE[cos_idx(carrier_phase_r)];
    end
    s1_last_r <= s0_last_r;
    mix_r     <= $signed({1'b0, s0_sample_r}) * car_cos_r;
  end

  // arithmetic shift by 15 is the floor of the scaled product
  assign tok_out.valid = s1_valid_r;
  assign tok_out.last  = s1_last_r;
  assign tok_out.m     = mix_r[MIX_W-1:15];

endmodule

[src/dbc_cell.sv]
// ----------------------------------------------------------------------------
// dbc_cell
// one frequency bin: phase accumulator, sine lookup, multiply and saturating
// accumulate; hands the mixed value and its step plus the spacing on to the next bin
// ----------------------------------------------------------------------------
module dbc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  dbc_pkg::tok_t    tok_in,
  input  dbc_pkg::phase_t  step_in,
  input  dbc_pkg::phase_t  spacing,
  input  logic             take,
  output dbc_pkg::tok_t    tok_out,
  output dbc_pkg::phase_t  step_out,
  output dbc_pkg::res_t    res
);
  import dbc_pkg::*;

  phase_t                    step_r;
  phase_t                    phase_r;
  logic                      a_valid_r;
  logic                      a_last_r;
  logic signed [M_W-1:0]     a_m_r;
  sine_t                     sin_r;
  sine_t                     cos_r;
  logic                      b_valid_r;
  logic                      b_last_r;
  logic signed [CPROD_W-1:0] prod_re_r;
  logic signed [CPROD_W-1:0] prod_im_r;
  logic signed [SUM_W-1:0]   re_sum_r;
  logic signed [SUM_W-1:0]   im_sum_r;
  logic signed [SUM_W-1:0]   re_nxt;
  logic signed [SUM_W-1:0]   im_nxt;
  logic signed [SUM_W-1:0]   res_re_r;
  logic signed [SUM_W-1:0]   res_im_r;
  logic                      res_full_r;

  function automatic logic signed [SUM_W-1:0] sat_add(
    logic signed [SUM_W-1:0]   s,
    logic signed [CPROD_W-1:0] d
  );
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    if (r[SUM_W] != r[SUM_W-1]) return r[SUM_W] ? SUM_MIN : SUM_MAX;
    return r[SUM_W-1:0];
  endfunction

  // step of this bin is the previous bin's step plus the spacing
  always_ff @(posedge clk) begin
    step_r <= step_in;
  end
  assign step_out = step_r + spacing;

  assign re_nxt = sat_add(re_sum_r, prod_re_r);
  assign im_nxt = sat_add(im_sum_r, prod_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      re_sum_r   <= '0;
      im_sum_r   <= '0;
      res_full_r <= 1'b0;
    end else begin
      a_valid_r <= tok_in.valid;
      b_valid_r <= a_valid_r;
      if (tok_in.valid) begin
        phase_r <= tok_in.last ? '0 : phase_r + step_r;
      end
      if (b_valid_r) begin
        if (b_last_r) begin
          re_sum_r   <= '0;
          im_sum_r   <= '0;
          res_full_r <= 1'b1;
        end else begin
          re_sum_r <= re_nxt;
          im_sum_r <= im_nxt;
        end
      end else if (take) begin
        res_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      a_m_r    <= tok_in.m;
      a_last_r <= tok_in.last;
      sin_r    <= SINE_TABLE[sine_idx(phase_r)];
      cos_r    <= SINE_TABLE[cos_idx(phase_r)];
    end
    b_last_r  <= a_last_r;
    prod_re_r <= a_m_r * cos_r;
    prod_im_r <= -(a_m_r * sin_r);
    if (b_valid_r && b_last_r) begin
      res_re_r <= re_nxt;
      res_im_r <= im_nxt;
    end
  end

  assign tok_out.valid = a_valid_r;
  assign tok_out.last  = a_last_r;
  assign tok_out.m     = a_m_r;

  assign res.full = res_full_r;
  assign res.re   = res_re_r;
  assign res.im   = res_im_r;

endmodule

[src/demodulating_bin_correlator.sv]
// ----------------------------------------------------------------------------
// demodulating_bin_correlator
// carrier-mixed multi-bin correlator over blocks of converter samples
// ----------------------------------------------------------------------------
// result path: the sample marked last passes the mixer (2 stages), then moves
//   one cell per cycle along the row until it closes the sum of bin b
// throughput: one sample per cycle within a block; after the last sample the
//   input holds off until all NUM_BINS results are taken
// reset: phases and sums cleared, step registers at their default values
// ----------------------------------------------------------------------------
module demodulating_bin_correlator (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_sample,
  input  logic               in_last_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_bin_index,
  output logic signed [40:0] out_real_part,
  output logic signed [40:0] out_imag_part,
  output logic               out_last_bin,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import dbc_pkg::*;

  // step registers
  phase_t carrier_step_r;
  phase_t first_step_r;
  phase_t spacing_r;

  // block control
  logic             busy_r;
  logic [BIN_W-1:0] out_bin_r;
  logic             in_accept;
  logic             out_accept;
  logic             out_is_last;

  // cell row wiring
  tok_t                tok_chain  [NUM_BINS];
  phase_t              step_chain [NUM_BINS];
  res_t                res        [NUM_BINS];
  logic [NUM_BINS-1:0] take_vec;
  res_t                res_sel;

  // registers accept a write in every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_step_r <= PHASE_BITS'(CARRIER_STEP_RST);
      first_step_r   <= PHASE_BITS'(FIRST_BIN_STEP_RST);
      spacing_r      <= PHASE_BITS'(BIN_SPACING_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CARRIER_STEP:   carrier_step_r <= PHASE_BITS'(cfg_data);
        CFG_FIRST_BIN_STEP: first_step_r   <= PHASE_BITS'(cfg_data);
        CFG_BIN_SPACING:    spacing_r      <= PHASE_BITS'(cfg_data);
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // a block ends with its last sample; nothing more comes in until every
  // bin result of that block has been handed out
  assign in_ready    = !busy_r;
  assign in_accept   = in_valid && in_ready;
  assign out_accept  = out_valid && out_ready;
  assign out_is_last = (out_bin_r == BIN_W'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_bin_r <= '0;
    end else begin
      if (in_accept && in_last_sample) begin
        busy_r <= 1'b1;
      end else if (out_accept && out_is_last) begin
        busy_r <= 1'b0;
      end
      if (out_accept) begin
        out_bin_r <= out_is_last ? '0 : out_bin_r + 1'b1;
      end
    end
  end

  // carrier mixing ahead of the bin row
  dbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .sample       (in_sample),
    .last_sample  (in_last_sample),
    .carrier_step (carrier_step_r),
    .tok_out      (tok_chain[0])
  );

  // bin 0 steps by the first bin step, each later bin adds the spacing
  assign step_chain[0] = first_step_r;

  // row of bin cells: the mixed value moves one bin per cycle
  for (genvar b = 0; b < NUM_BINS; b++) begin : g_bin
    assign take_vec[b] = out_accept && (out_bin_r == BIN_W'(b));
    if (b < NUM_BINS - 1) begin : g_mid
      dbc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_in   (tok_chain[b]),
        .step_in  (step_chain[b]),
        .spacing  (spacing_r),
        .take     (take_vec[b]),
        .tok_out  (tok_chain[b+1]),
        .step_out (step_chain[b+1]),
        .res      (res[b])
      );
    end else begin : g_end
      dbc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_in   (tok_chain[b]),
        .step_in  (step_chain[b]),
        .spacing  (spacing_r),
        .take     (take_vec[b]),
        .tok_out  (),
        .step_out (),
        .res      (res[b])
      );
    end
  end

  // results leave in bin order; each bin waits in its cell until taken
  assign res_sel       = res[out_bin_r];
  assign out_valid     = res_sel.full;
  assign out_bin_index = BIN_IDX_W'(out_bin_r);
  assign out_real_part = res_sel.re;
  assign out_imag_part = res_sel.im;
  assign out_last_bin  = out_is_last;

  // a result is only ever on offer while its block holds the input off
  a_out_only_when_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result offered outside a finished block");

  // the last sample of a block closes the input
  a_last_closes_input : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_sample) |=> !in_ready)
    else $error("input still open after last sample");

  // handing out the final bin reopens the input
  a_final_bin_reopens : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_bin) |=> in_ready)
    else $error("input not reopened after final bin");

endmodule

[test/tb_demodulating_bin_correlator.sv]
// ----------------------------------------------------------------------------
// tb_demodulating_bin_correlator
// self-checking bench for the carrier-mixed multi-bin correlator: samples are
// pushed through the valid/ready input with random gaps, the expected bin
// sums are worked out in a bit-exact predictor and every result transaction
// is compared field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb_demodulating_bin_correlator;
  import dbc_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int CLK_PERIOD      = 2 * CLK_HALF;
  localparam int SETTLE_CYCLES   = 2 * (NUM_BINS + 4);  // two full pipeline flushes
  localparam int DRAIN_LIMIT     = 5000;
  localparam int WATCHDOG_CYCLES = 250_000;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 45;
  localparam int LONG_RUN        = 20;                  // full-scale block, no idling

  // register slot with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // step values after reset
  localparam logic [CFG_DATA_W-1:0] CARRIER_STEP_INIT = 24'd5592405;
  localparam logic [CFG_DATA_W-1:0] BIN_STEP_INIT     = 24'd2237;
  localparam logic [CFG_DATA_W-1:0] HALF_TURN_STEP    = 24'h800000;

  localparam phase_t QUARTER_TURN   = phase_t'(1) << (PHASE_BITS - 2);
  localparam longint HALF_TURN_Q30  = 64'sd3373259426;
  localparam longint ACC_TOP        = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint ACC_BOTTOM     = -(64'sd1 <<< (SUM_W - 1));

  typedef struct {
    logic [BIN_IDX_W-1:0]    bin_index;
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    last_bin;
  } bin_result_t;

  // --------------------------------------------------------------------------
  // bin sum predictor and store of pending bin results
  // --------------------------------------------------------------------------
  class bin_sum_predictor;
    sine_t                   sine_lut [SINE_DEPTH];
    phase_t                  carrier_step;
    phase_t                  first_step;
    phase_t                  spacing_step;
    phase_t                  carrier_ph;
    phase_t                  bin_ph [NUM_BINS];
    logic signed [SUM_W-1:0] re_acc [NUM_BINS];
    logic signed [SUM_W-1:0] im_acc [NUM_BINS];
    bin_result_t             pending_bins [$];
    int                      mismatches;

    function new();
      for (int k = 0; k < SINE_DEPTH; k++) sine_lut[k] = rom_value(k);
      carrier_step = phase_t'(CARRIER_STEP_INIT);
      first_step   = phase_t'(BIN_STEP_INIT);
      spacing_step = phase_t'(BIN_STEP_INIT);
      carrier_ph   = '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        bin_ph[b] = '0;
        re_acc[b] = '0;
        im_acc[b] = '0;
      end
      mismatches = 0;
    endfunction

    // q1.15 table entry from a q30 taylor series, angle folded into +-pi/2
    function sine_t rom_value(int unsigned k);
      longint          ang;
      longint          acc;
      longint          v;
      longint unsigned mag;
      longint unsigned term;
      bit              neg;
      ang = (2 * HALF_TURN_Q30 * longint'(k)) / SINE_DEPTH;
      if (ang > HALF_TURN_Q30) ang = ang - 2 * HALF_TURN_Q30;
      if (ang > HALF_TURN_Q30 / 2) ang = HALF_TURN_Q30 - ang;
      if (ang < -(HALF_TURN_Q30 / 2)) ang = -HALF_TURN_Q30 - ang;
      neg  = (ang < 0);
      mag  = neg ? -ang : ang;
      term = mag;
      acc  = mag;
      for (int n = 1; n <= 12; n++) begin
        term = (term * mag) >> 30;
        term = (term * mag) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      if (acc < 0) acc = 0;
      v = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      return sine_t'(neg ? -v : v);
    endfunction

    function sine_t sine_of(phase_t p);
      return sine_lut[(longint'(p) * SINE_DEPTH) >> PHASE_BITS];
    endfunction

    function sine_t cosine_of(phase_t p);
      return sine_of(p + QUARTER_TURN);
    endfunction

    function logic signed [SUM_W-1:0] clamp_sum(longint v);
      if (v > ACC_TOP) return SUM_W'(ACC_TOP);
      if (v < ACC_BOTTOM) return SUM_W'(ACC_BOTTOM);
      return SUM_W'(v);
    endfunction

    function void set_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CARRIER_STEP:   carrier_step = phase_t'(val);
        CFG_FIRST_BIN_STEP: first_step   = phase_t'(val);
        CFG_BIN_SPACING:    spacing_step = phase_t'(val);
        default: ;
      endcase
    endfunction

    // one accepted sample: mix, correlate into every bin, emit on last
    function void take_sample(logic [SAMPLE_W-1:0] s, logic is_last);
      longint      mixed;
      phase_t      bin_step;
      bin_result_t r;
      mixed = (longint'(s) * longint'(cosine_of(carrier_ph))) >>> 15;
      for (int b = 0; b < NUM_BINS; b++) begin
        bin_step  = first_step + phase_t'(b) * spacing_step;
        re_acc[b] = clamp_sum(longint'(re_acc[b]) + mixed * longint'(cosine_of(bin_ph[b])));
        im_acc[b] = clamp_sum(longint'(im_acc[b]) - mixed * longint'(sine_of(bin_ph[b])));
        bin_ph[b] = bin_ph[b] + bin_step;
      end
      carrier_ph = carrier_ph + carrier_step;
      if (is_last) begin
        for (int b = 0; b < NUM_BINS; b++) begin
          r.bin_index = BIN_IDX_W'(b);
          r.re        = re_acc[b];
          r.im        = im_acc[b];
          r.last_bin  = (b == NUM_BINS - 1);
          pending_bins.push_back(r);
          re_acc[b] = '0;
          im_acc[b] = '0;
          bin_ph[b] = '0;
        end
        carrier_ph = '0;
      end
    endfunction

    function int outstanding();
      return pending_bins.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_bin(logic [BIN_IDX_W-1:0] idx, logic signed [SUM_W-1:0] re,
                   logic signed [SUM_W-1:0] im, logic lb);
      bin_result_t want;
      string       bad;
      if (pending_bins.size() == 0) begin
        report_mismatch($sformatf("result for bin %0d with nothing pending", idx));
        return;
      end
      want = pending_bins.pop_front();
      bad  = "";
      if (idx !== want.bin_index)
        bad = {bad, $sformatf(" bin_index %0d/%0d", idx, want.bin_index)};
      if (re !== want.re)
        bad = {bad, $sformatf(" real_part %0d/%0d", re, want.re)};
      if (im !== want.im)
        bad = {bad, $sformatf(" imag_part %0d/%0d", im, want.im)};
      if (lb !== want.last_bin)
        bad = {bad, $sformatf(" last_bin %0b/%0b", lb, want.last_bin)};
      if (bad != "")
        report_mismatch($sformatf("bin %0d got/want:%s", want.bin_index, bad));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_sample      = '0;
  logic                    in_last_sample = 1'b0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic [BIN_IDX_W-1:0]    out_bin_index;
  logic signed [SUM_W-1:0] out_real_part;
  logic signed [SUM_W-1:0] out_imag_part;
  logic                    out_last_bin;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data       = '0;

  // set while both sides run flat out with no idling
  bit steady = 1'b0;

  bin_sum_predictor bin_sums;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  demodulating_bin_correlator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin_index  (out_bin_index),
    .out_real_part  (out_real_part),
    .out_imag_part  (out_imag_part),
    .out_last_bin   (out_last_bin),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // result side: random back-pressure, every taken transaction is checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // values read here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      bin_sums.check_bin(out_bin_index, out_real_part, out_imag_part, out_last_bin);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one sample transaction, with random idle cycles ahead of it unless steady is set
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= is_last;
    do @(posedge clk); while (!in_ready);
    bin_sums.take_sample(s, is_last);
  endtask

  // one register write; valid is left high so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    bin_sums.set_step(idx, val);
  endtask

  // full step set, optionally poking the unmapped slot as well
  task automatic load_steps(input logic [CFG_DATA_W-1:0] carrier,
                            input logic [CFG_DATA_W-1:0] first,
                            input logic [CFG_DATA_W-1:0] spacing,
                            input bit poke_unmapped);
    write_reg(CFG_CARRIER_STEP, carrier);
    write_reg(CFG_FIRST_BIN_STEP, first);
    write_reg(CFG_BIN_SPACING, spacing);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // hold the input until every pending result is out, then let the
  // pipeline flush so that no sample of an unfinished block is still in flight
  task automatic drain_results();
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && bin_sums.outstanding() != 0; n++)
      @(posedge clk);
    if (bin_sums.outstanding() != 0) begin
      bin_sums.report_mismatch($sformatf("%0d bin results never arrived",
                                         bin_sums.outstanding()));
      bin_sums.pending_bins.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return HALF_TURN_STEP;
      3:       return CFG_DATA_W'($urandom_range(0, 24'h3FFFF));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                  run_left;
    bit                  held;
    logic [SAMPLE_W-1:0] smp;
    run_left = 0;
    held     = 1'b0;
    bin_sums = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // steps as after reset: single-sample blocks, then a block where the
    // carrier swings negative and the mixed value rounds towards minus
    send_sample(12'hFFF, 1'b1);
    send_sample(12'h000, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'h000, 1'b0);
    send_sample(12'hAAA, 1'b0);
    send_sample(12'h555, 1'b0);
    send_sample(12'hFFF, 1'b1);

    // all-ones carrier and bin steps with zero spacing, every phase wraps on each sample
    drain_results();
    load_steps('1, '1, '0, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'h000, 1'b0);
    send_sample(12'hFFF, 1'b1);

    // zero carrier and bin 0 standing still; block left open at the end
    drain_results();
    load_steps('0, '0, '1, 1'b0);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'h001, 1'b0);
    send_sample(12'h800, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'hFFF, 1'b0);

    // steps changed in the middle of a block
    drain_results();
    load_steps(HALF_TURN_STEP, QUARTER_TURN, HALF_TURN_STEP, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'hFFF, 1'b1);

    // full-scale block with both sides running flat out
    drain_results();
    load_steps('0, '0, HALF_TURN_STEP, 1'b0);
    steady = 1'b1;
    for (int i = 0; i < LONG_RUN; i++)
      send_sample({10'h3FF, 2'($urandom)}, i == LONG_RUN - 1);

    // random blocks under random steps; one phase without any idling,
    // blocks may span a change of steps
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      load_steps(pick_step(), pick_step(), pick_step(), 1'($urandom_range(0, 1)));
      steady = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (run_left == 0) run_left = $urandom_range(1, 14);
        run_left--;
        case ($urandom_range(0, 9))
          0:       smp = '0;
          1:       smp = '1;
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_sample(smp, run_left == 0);
        // sender holds off once until the results of a block are all out
        if (ph == 1 && i >= 20 && !held && run_left == 0) begin
          held = 1'b1;
          drain_results();
        end
      end
    end

    drain_results();
    if (bin_sums.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop if the handshakes never complete
  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("run timed out");
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
src/dbc_pkg.sv
src/dbc_front.sv
src/dbc_cell.sv
src/demodulating_bin_correlator.sv
test/tb_demodulating_bin_correlator.sv
